>>> src/qpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpa_pkg: shared types, codes and helpers of the Q12.20 phasor ALU
// Transaction structs, action codes, CORDIC turn table, rounding multiply
// and quotient saturation.
// ----------------------------------------------------------------------------
package qpa_pkg;

    localparam int FRAC_BITS_DEF = 20;
    localparam int STEPS         = 32;
    // front (2) + root/CORDIC chain + divider setup (1) + divider chain + output (1)
    localparam int LATENCY       = 2 + STEPS + 1 + STEPS + 1;

    localparam logic [3:0] ACT_ADD   = 4'd0;
    localparam logic [3:0] ACT_SUB   = 4'd1;
    localparam logic [3:0] ACT_MUL   = 4'd2;
    localparam logic [3:0] ACT_DIV   = 4'd3;
    localparam logic [3:0] ACT_REL   = 4'd4;
    localparam logic [3:0] ACT_IREL  = 4'd5;
    localparam logic [3:0] ACT_MAG   = 4'd6;
    localparam logic [3:0] ACT_PHASE = 4'd7;
    localparam logic [3:0] ACT_NORM  = 4'd8;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } op_t;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               div_zero;
    } res_t;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] pre_re;
        logic signed [31:0] pre_im;
        logic signed [31:0] m;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic               ph_zero;
    } side_t;

    typedef struct packed {
        logic [63:0]        v;
        logic [63:0]        root;
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic [31:0]        ang;
        side_t              side;
    } vec_t;

    typedef struct packed {
        logic [63:0]        rem_re;
        logic [63:0]        rem_im;
        logic [31:0]        den;
        logic [31:0]        q_re;
        logic [31:0]        q_im;
        logic               nneg_re;
        logic               nneg_im;
        logic               dneg;
        logic               ovf_re;
        logic               ovf_im;
        logic               zero;
        logic               is_div;
        logic signed [31:0] fin_re;
        logic signed [31:0] fin_im;
    } dv_t;

    function automatic logic [31:0] turn_tab(input logic [4:0] idx);
        logic [31:0] t;
        case (idx)
            5'd0:    t = 32'd536870912;
            5'd1:    t = 32'd316933406;
            5'd2:    t = 32'd167458907;
            5'd3:    t = 32'd85004756;
            5'd4:    t = 32'd42667331;
            5'd5:    t = 32'd21354465;
            5'd6:    t = 32'd10679838;
            5'd7:    t = 32'd5340245;
            5'd8:    t = 32'd2670163;
            5'd9:    t = 32'd1335087;
            5'd10:   t = 32'd667544;
            5'd11:   t = 32'd333772;
            5'd12:   t = 32'd166886;
            5'd13:   t = 32'd83443;
            5'd14:   t = 32'd41722;
            5'd15:   t = 32'd20861;
            5'd16:   t = 32'd10430;
            5'd17:   t = 32'd5215;
            5'd18:   t = 32'd2608;
            5'd19:   t = 32'd1304;
            5'd20:   t = 32'd652;
            5'd21:   t = 32'd326;
            5'd22:   t = 32'd163;
            5'd23:   t = 32'd81;
            5'd24:   t = 32'd41;
            5'd25:   t = 32'd20;
            5'd26:   t = 32'd10;
            5'd27:   t = 32'd5;
            5'd28:   t = 32'd3;
            5'd29:   t = 32'd1;
            5'd30:   t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

    // round half up and keep the low word
    function automatic logic signed [31:0] rmpy(input logic signed [63:0] p, input int frac);
        logic signed [63:0] s;
        s = (p + (64'sd1 <<< (frac - 1))) >>> frac;
        return s[31:0];
    endfunction

    function automatic logic [31:0] sat_quot(input logic [31:0] q, input logic nneg,
                                             input logic dneg, input logic ovf,
                                             input logic zero);
        logic [31:0] r;
        if (zero)
            r = nneg ? SAT_NEG : SAT_POS;
        else if (nneg ^ dneg)
            r = (ovf || q > SAT_NEG) ? SAT_NEG : (32'd0 - q);
        else
            r = (ovf || q[31]) ? SAT_POS : q;
        return r;
    endfunction

endpackage

>>> src/q20_phasor_alu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q20_phasor_alu_core: Q12.20 complex phasor ALU
// Fully pipelined add, subtract, multiply, divide, magnitude, phase, normalize.
// ----------------------------------------------------------------------------
// One transaction is taken in every cycle and busy stays low. Every
// transaction, whatever its action, returns its result with done after
// passing through two product/sum stages, a chain of 32 cells that
// resolve one square-root bit and one CORDIC rotation each, a divider
// setup stage, a chain of 32 restoring-divider cells, and the output
// register. Results are shown for one cycle only; the receiver must take
// them when done is high.
module q20_phasor_alu_core #(
    parameter int FRAC_BITS = qpa_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  qpa_pkg::op_t  op,
    output logic          done,
    output qpa_pkg::res_t res
);
    import qpa_pkg::*;

    vec_t vec_w [STEPS+1];
    logic vec_v [STEPS+1];
    dv_t  dv_w  [STEPS+1];
    logic dv_v  [STEPS+1];

    res_t res_reg, res_next;
    logic done_reg;

    qpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (start),
        .op      (op),
        .vld_out (vec_v[0]),
        .vec     (vec_w[0])
    );

    for (genvar k = 0; k < STEPS; k++)
    begin : g_vec
        qpa_vec_cell #(.STEP(k)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .vld_in  (vec_v[k]),
            .vi      (vec_w[k]),
            .vld_out (vec_v[k+1]),
            .vo      (vec_w[k+1])
        );
    end

    qpa_div_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (vec_v[STEPS]),
        .vi      (vec_w[STEPS]),
        .vld_out (dv_v[0]),
        .dv      (dv_w[0])
    );

    for (genvar k = 0; k < STEPS; k++)
    begin : g_div
        qpa_div_cell #(.STEP(k)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .vld_in  (dv_v[k]),
            .di      (dv_w[k]),
            .vld_out (dv_v[k+1]),
            .dq      (dv_w[k+1])
        );
    end

    always_comb
    begin
        if (dv_w[STEPS].is_div)
        begin
            res_next.res_re = sat_quot(dv_w[STEPS].q_re, dv_w[STEPS].nneg_re,
                                       dv_w[STEPS].dneg, dv_w[STEPS].ovf_re,
                                       dv_w[STEPS].zero);
            res_next.res_im = sat_quot(dv_w[STEPS].q_im, dv_w[STEPS].nneg_im,
                                       dv_w[STEPS].dneg, dv_w[STEPS].ovf_im,
                                       dv_w[STEPS].zero);
            res_next.div_zero = dv_w[STEPS].zero;
        end
        else
        begin
            res_next.res_re = dv_w[STEPS].fin_re;
            res_next.res_im = dv_w[STEPS].fin_im;
            res_next.div_zero = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_v[STEPS];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign res  = res_reg;

endmodule

>>> src/qpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpa_front: product and sum stages
// Six registered products, then rounding, sums and CORDIC pre-rotation.
// ----------------------------------------------------------------------------
module qpa_front #(
    parameter int FRAC_BITS = qpa_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vld_in,
    input  qpa_pkg::op_t  op,
    output logic          vld_out,
    output qpa_pkg::vec_t vec
);
    import qpa_pkg::*;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        logic signed [63:0] p_rr;
        logic signed [63:0] p_ii;
        logic signed [63:0] p_ir;
        logic signed [63:0] p_ri;
        logic signed [63:0] p_s0;
        logic signed [63:0] p_s1;
    } mul_t;

    mul_t  s1_reg, s1_next;
    vec_t  vec_reg, vec_next;
    logic  v1_reg, v2_reg;
    logic  sel_a;
    logic signed [31:0] sq0, sq1;
    logic signed [31:0] r_rr, r_ii, r_ir, r_ri, r_s0, r_s1;
    logic signed [35:0] x0, y0;

    always_comb
    begin
        // squares of A for magnitude and normalize, of B otherwise
        sel_a = (op.action == ACT_MAG) || (op.action == ACT_NORM);
        sq0 = sel_a ? op.a_re : op.b_re;
        sq1 = sel_a ? op.a_im : op.b_im;
        s1_next.action = op.action;
        s1_next.ar = op.a_re;
        s1_next.ai = op.a_im;
        s1_next.br = op.b_re;
        s1_next.bi = op.b_im;
        s1_next.p_rr = op.a_re * op.b_re;
        s1_next.p_ii = op.a_im * op.b_im;
        s1_next.p_ir = op.a_im * op.b_re;
        s1_next.p_ri = op.a_re * op.b_im;
        s1_next.p_s0 = sq0 * sq0;
        s1_next.p_s1 = sq1 * sq1;
    end

    always_comb
    begin
        r_rr = rmpy(s1_reg.p_rr, FRAC_BITS);
        r_ii = rmpy(s1_reg.p_ii, FRAC_BITS);
        r_ir = rmpy(s1_reg.p_ir, FRAC_BITS);
        r_ri = rmpy(s1_reg.p_ri, FRAC_BITS);
        r_s0 = rmpy(s1_reg.p_s0, FRAC_BITS);
        r_s1 = rmpy(s1_reg.p_s1, FRAC_BITS);
        vec_next.side.action = s1_reg.action;
        case (s1_reg.action)
            ACT_ADD:
            begin
                vec_next.side.pre_re = s1_reg.ar + s1_reg.br;
                vec_next.side.pre_im = s1_reg.ai + s1_reg.bi;
            end
            ACT_SUB:
            begin
                vec_next.side.pre_re = s1_reg.ar - s1_reg.br;
                vec_next.side.pre_im = s1_reg.ai - s1_reg.bi;
            end
            ACT_MUL, ACT_IREL:
            begin
                vec_next.side.pre_re = r_rr - r_ii;
                vec_next.side.pre_im = r_ir + r_ri;
            end
            ACT_DIV, ACT_REL:
            begin
                vec_next.side.pre_re = r_rr + r_ii;
                vec_next.side.pre_im = r_ir - r_ri;
            end
            default:
            begin
                vec_next.side.pre_re = 32'sd0;
                vec_next.side.pre_im = 32'sd0;
            end
        endcase
        vec_next.side.m = r_s0 + r_s1;
        vec_next.side.ar = s1_reg.ar;
        vec_next.side.ai = s1_reg.ai;
        vec_next.side.ph_zero = (s1_reg.ar == 32'sd0) && (s1_reg.ai == 32'sd0);
        vec_next.v = 64'(unsigned'(s1_reg.p_s0)) + 64'(unsigned'(s1_reg.p_s1));
        vec_next.root = 64'd0;
        // vectoring runs on x = im, y = re; rotate a half turn when x < 0
        x0 = 36'(s1_reg.ai);
        y0 = 36'(s1_reg.ar);
        if (s1_reg.ai < 0)
        begin
            vec_next.x = -x0;
            vec_next.y = -y0;
            vec_next.ang = SAT_NEG;
        end
        else
        begin
            vec_next.x = x0;
            vec_next.y = y0;
            vec_next.ang = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= vld_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        vec_reg <= vec_next;
    end

    assign vld_out = v2_reg;
    assign vec     = vec_reg;

endmodule

>>> src/qpa_vec_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpa_vec_cell: one step of the integer square root and of the CORDIC
// Each cell resolves one root bit and one vectoring micro-rotation.
// ----------------------------------------------------------------------------
module qpa_vec_cell #(
    parameter int STEP = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vld_in,
    input  qpa_pkg::vec_t vi,
    output logic          vld_out,
    output qpa_pkg::vec_t vo
);
    import qpa_pkg::*;

    localparam logic [63:0] BIT  = 64'd1 << (62 - 2 * STEP);
    localparam logic [31:0] TURN = turn_tab(5'(STEP));

    vec_t vo_reg, vo_next;
    logic vld_reg;
    logic [63:0] trial;
    logic signed [35:0] dx, dy;

    always_comb
    begin
        vo_next = vi;
        trial = vi.root + BIT;
        if (vi.v >= trial)
        begin
            vo_next.v = vi.v - trial;
            vo_next.root = (vi.root >> 1) + BIT;
        end
        else
        begin
            vo_next.root = vi.root >> 1;
        end
        dx = vi.y >>> STEP;
        dy = vi.x >>> STEP;
        if (vi.y > 0)
        begin
            vo_next.x = vi.x + dx;
            vo_next.y = vi.y - dy;
            vo_next.ang = vi.ang + TURN;
        end
        else
        begin
            vo_next.x = vi.x - dx;
            vo_next.y = vi.y + dy;
            vo_next.ang = vi.ang - TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        vo_reg <= vo_next;
    end

    assign vld_out = vld_reg;
    assign vo      = vo_reg;

endmodule

>>> src/qpa_div_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpa_div_prep: divider setup stage
// Finishes magnitude and phase, picks numerators and divisor, checks overflow.
// ----------------------------------------------------------------------------
module qpa_div_prep #(
    parameter int FRAC_BITS = qpa_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vld_in,
    input  qpa_pkg::vec_t vi,
    output logic          vld_out,
    output qpa_pkg::dv_t  dv
);
    import qpa_pkg::*;

    dv_t  dv_reg, dv_next;
    logic vld_reg;
    logic [31:0] mag, ph, d, an_re, an_im;
    logic [32:0] ph_sum, ph_mask;
    logic signed [31:0] n_re, n_im;
    logic [63:0] num_re, num_im, den_top;

    always_comb
    begin
        mag = (vi.root > 64'(SAT_POS)) ? SAT_POS : vi.root[31:0];
        ph_sum = {1'b0, vi.ang} + (33'd1 << (31 - FRAC_BITS));
        ph_mask = (33'd1 << FRAC_BITS) - 33'd1;
        ph = vi.side.ph_zero ? 32'd0 : 32'((ph_sum >> (32 - FRAC_BITS)) & ph_mask);

        if (vi.side.action == ACT_NORM)
        begin
            n_re = vi.side.ar;
            n_im = vi.side.ai;
            d = mag;
        end
        else
        begin
            n_re = vi.side.pre_re;
            n_im = vi.side.pre_im;
            d = vi.side.m;
        end
        an_re = n_re[31] ? (32'd0 - n_re) : n_re;
        an_im = n_im[31] ? (32'd0 - n_im) : n_im;
        dv_next.den = d[31] ? (32'd0 - d) : d;
        num_re = {32'd0, an_re} << FRAC_BITS;
        num_im = {32'd0, an_im} << FRAC_BITS;
        den_top = {dv_next.den, 32'd0};
        dv_next.rem_re = num_re;
        dv_next.rem_im = num_im;
        dv_next.q_re = 32'd0;
        dv_next.q_im = 32'd0;
        dv_next.nneg_re = n_re[31];
        dv_next.nneg_im = n_im[31];
        dv_next.dneg = d[31];
        // quotient would need more than 32 magnitude bits
        dv_next.ovf_re = num_re >= den_top;
        dv_next.ovf_im = num_im >= den_top;
        dv_next.zero = (d == 32'd0);
        dv_next.is_div = (vi.side.action == ACT_DIV) || (vi.side.action == ACT_NORM);

        case (vi.side.action)
            ACT_MAG:
            begin
                dv_next.fin_re = mag;
                dv_next.fin_im = 32'sd0;
            end
            ACT_PHASE:
            begin
                dv_next.fin_re = ph;
                dv_next.fin_im = 32'sd0;
            end
            default:
            begin
                dv_next.fin_re = vi.side.pre_re;
                dv_next.fin_im = vi.side.pre_im;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        dv_reg <= dv_next;
    end

    assign vld_out = vld_reg;
    assign dv      = dv_reg;

endmodule

>>> src/qpa_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpa_div_cell: one restoring division step on both lanes
// Resolves one quotient bit of the real and of the imaginary quotient.
// ----------------------------------------------------------------------------
module qpa_div_cell #(
    parameter int STEP = 0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         vld_in,
    input  qpa_pkg::dv_t di,
    output logic         vld_out,
    output qpa_pkg::dv_t dq
);
    import qpa_pkg::*;

    localparam int SHIFT = qpa_pkg::STEPS - 1 - STEP;

    dv_t  dq_reg, dq_next;
    logic vld_reg;
    logic [63:0] dsh;
    logic take_re, take_im;

    always_comb
    begin
        dq_next = di;
        dsh = {32'd0, di.den} << SHIFT;
        take_re = di.rem_re >= dsh;
        take_im = di.rem_im >= dsh;
        if (take_re)
            dq_next.rem_re = di.rem_re - dsh;
        if (take_im)
            dq_next.rem_im = di.rem_im - dsh;
        dq_next.q_re = {di.q_re[30:0], take_re};
        dq_next.q_im = {di.q_im[30:0], take_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        dq_reg <= dq_next;
    end

    assign vld_out = vld_reg;
    assign dq      = dq_reg;

endmodule

>>> src/qpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpa_checker: port-level checks of the phasor ALU
// Latency, divide-by-zero saturation and scalar results, bound to the core.
// ----------------------------------------------------------------------------
module qpa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input qpa_pkg::op_t  op,
    input logic          done,
    input qpa_pkg::res_t res
);
    import qpa_pkg::*;

    // every result traces back to a transaction taken a fixed time earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching transaction");

    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.div_zero) |->
            ((res.res_re == SAT_POS || res.res_re == SAT_NEG) &&
             (res.res_im == SAT_POS || res.res_im == SAT_NEG)))
        else $error("divide by zero result not saturated");

    a_zero_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.div_zero) |->
            ($past(op.action, LATENCY) == ACT_DIV || $past(op.action, LATENCY) == ACT_NORM))
        else $error("divide by zero flag on non-dividing action");

    a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(op.action, LATENCY) == ACT_MAG ||
                  $past(op.action, LATENCY) == ACT_PHASE)) |->
            (res.res_im == 32'sd0 && !res.res_re[31]))
        else $error("scalar result malformed");

endmodule

bind q20_phasor_alu_core qpa_checker u_qpa_checker (.*);
